>>> rtl/core/dst_pkg.sv
// Shared types and constants for the daily sighting tracker.
package dst_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 128;

	localparam int ADDR_W  = 24;
	localparam int COUNT_W = 16;
	localparam int TIME_W  = 32;
	localparam int DAY_W   = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [TIME_W-1:0] RETURN_GAP_RESET     = 32'd300000;
	localparam logic [TIME_W-1:0] RETURN_DISPLAY_RESET = 32'd600000;

	localparam logic [0:0] CFG_RETURN_GAP     = 1'b0;
	localparam logic [0:0] CFG_RETURN_DISPLAY = 1'b1;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_QUERY  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CLASS_NEW       = 2'd0,
		CLASS_RETURNING = 2'd1,
		CLASS_SEEN      = 2'd2
	} sight_class_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT,
		ST_MISS
	} state_t;

	typedef struct packed {
		opcode_t             op;
		logic [ADDR_W-1:0]   address;
		logic                address_present;
		logic [TIME_W-1:0]   now_ms;
		logic                time_valid;
		logic [DAY_W-1:0]    day_number;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  last_seen;
		logic [TIME_W-1:0]  returned_at;
		logic [TIME_W-1:0]  gap;
	} entry_t;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] sight_count;
		sight_class_t       sight_class;
		logic [TIME_W-1:0]  gap_ms;
		logic               dropped;
	} result_t;

endpackage

>>> rtl/core/dst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/dst_engine.sv
// Search and update sequencer: linear scan of the table, then read-modify-write.
module dst_engine #(
	parameter int TABLE_DEPTH = dst_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  dst_pkg::item_t                 item,
	input  logic [dst_pkg::TIME_W-1:0]     return_gap,
	input  logic [dst_pkg::TIME_W-1:0]     return_display,
	output logic                           busy,
	output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
	input  logic [dst_pkg::ADDR_W-1:0]     addr_rdata,
	input  dst_pkg::entry_t                ent_rdata,
	output logic                           addr_we,
	output logic                           ent_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
	output logic [dst_pkg::ADDR_W-1:0]     addr_wdata,
	output dst_pkg::entry_t                ent_wdata,
	output dst_pkg::result_t               result,
	output logic                           done
);

	import dst_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t            state_q, state_d;
	item_t             item_q;
	entry_t            ent_q;
	logic [IW-1:0]     scan_q;
	logic [IW-1:0]     hit_idx_q;
	logic [CW-1:0]     used_q;
	logic [DAY_W-1:0]  stored_day_q;
	logic              day_known_q;
	result_t           res_q, res_d;
	logic              done_q, done_d;

	logic              accept;
	logic              clear_day;
	logic              table_empty;
	logic              match;
	logic              scan_last;
	logic              full;
	logic              is_record;
	logic              is_return;
	logic [TIME_W-1:0] gap_now;
	logic [TIME_W-1:0] since_ret;
	entry_t            upd;
	entry_t            fresh;
	sight_class_t      cls;

	assign accept    = (state_q == ST_IDLE) && start;
	assign clear_day = item.address_present && (item.op == OP_RECORD) && item.time_valid
		&& (!day_known_q || (item.day_number != stored_day_q));
	assign table_empty = clear_day || (used_q == '0);
	assign match     = (addr_rdata == item_q.address);
	assign scan_last = (CW'(scan_q) == (used_q - CW'(1)));
	assign full      = (used_q == CW'(TABLE_DEPTH));
	assign is_record = (item_q.op == OP_RECORD);

	// entry update on a hit, and its class as a query would see it
	always_comb begin
		gap_now   = item_q.now_ms - ent_q.last_seen;
		since_ret = item_q.now_ms - ent_q.returned_at;
		is_return = is_record && (gap_now > return_gap);
		upd       = ent_q;
		if (is_record) begin
			upd.last_seen = item_q.now_ms;
		end
		if (is_return) begin
			upd.returned_at = item_q.now_ms;
			upd.gap         = gap_now;
			if (ent_q.count != COUNT_MAX) begin
				upd.count = ent_q.count + COUNT_W'(1);
			end
		end
		if (upd.count <= COUNT_W'(1)) begin
			cls = CLASS_NEW;
		end else if (is_return ? (return_display != '0) : (since_ret < return_display)) begin
			cls = CLASS_RETURNING;
		end else begin
			cls = CLASS_SEEN;
		end
		fresh.count       = COUNT_W'(1);
		fresh.last_seen   = item_q.now_ms;
		fresh.returned_at = '0;
		fresh.gap         = '0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && item.address_present
					&& !((item.op == OP_RECORD) && !item.time_valid)) begin
					state_d = table_empty ? ST_MISS : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_d = ST_HIT;
				end else if (scan_last) begin
					state_d = ST_MISS;
				end
			end
			ST_HIT:  state_d = ST_IDLE;
			ST_MISS: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		addr_we   = 1'b0;
		ent_we    = 1'b0;
		mem_waddr = hit_idx_q;
		ent_wdata = upd;
		res_d     = '0;
		done_d    = 1'b0;
		mem_raddr = (state_q == ST_SCAN) ? scan_q + IW'(1) : '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !item.address_present) begin
					done_d = 1'b1;
				end else if (start && (item.op == OP_RECORD) && !item.time_valid) begin
					done_d        = 1'b1;
					res_d.dropped = 1'b1;
				end
			end
			ST_SCAN: begin
			end
			ST_HIT: begin
				done_d            = 1'b1;
				ent_we            = is_record;
				res_d.found       = 1'b1;
				res_d.sight_count = upd.count;
				res_d.sight_class = cls;
				res_d.gap_ms      = (cls == CLASS_RETURNING) ? upd.gap : '0;
			end
			ST_MISS: begin
				done_d = 1'b1;
				if (is_record) begin
					if (full) begin
						res_d.dropped = 1'b1;
					end else begin
						addr_we           = 1'b1;
						ent_we            = 1'b1;
						mem_waddr         = used_q[IW-1:0];
						ent_wdata         = fresh;
						res_d.sight_count = COUNT_W'(1);
						res_d.sight_class = CLASS_NEW;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			stored_day_q <= '0;
			day_known_q  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (accept && clear_day) begin
				stored_day_q <= item.day_number;
				day_known_q  <= 1'b1;
				used_q       <= '0;
			end else if ((state_q == ST_MISS) && is_record && !full) begin
				used_q <= used_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			item_q <= item;
			scan_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_q + IW'(1);
		end
		if ((state_q == ST_SCAN) && match) begin
			ent_q     <= ent_rdata;
			hit_idx_q <= scan_q;
		end
	end

	assign addr_wdata = item_q.address;
	assign busy       = (state_q != ST_IDLE);
	assign result     = res_q;
	assign done       = done_q;

endmodule

>>> rtl/core/daily_sighting_tracker.sv
// Daily sighting tracker top level: config registers, table memories, sequencer.
// An ignored or dropped-for-time word strobes done in the cycle after start; otherwise the word passes
// through the scan (skipped when the table is empty), then the hit or miss state, then the registered done.
// One word at a time: busy stays high during the linear scan over the address memory.
// A new word may start in the cycle busy falls; results are never held off by the receiver.
// Reset clears fill count and stored day, loads config defaults; table memories are not cleared.
module daily_sighting_tracker #(
	parameter int TABLE_DEPTH = dst_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            opcode,
	input  logic [dst_pkg::ADDR_W-1:0]      address,
	input  logic                            address_present,
	input  logic [dst_pkg::TIME_W-1:0]      now_ms,
	input  logic                            time_valid,
	input  logic [dst_pkg::DAY_W-1:0]       day_number,
	output logic                            done,
	output logic                            found,
	output logic [dst_pkg::COUNT_W-1:0]     sight_count,
	output logic [1:0]                      sight_class,
	output logic [dst_pkg::TIME_W-1:0]      gap_ms,
	output logic                            dropped,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [dst_pkg::TIME_W-1:0]      cfg_wdata
);

	import dst_pkg::*;

	localparam int IW    = $clog2(TABLE_DEPTH);
	localparam int ENT_W = $bits(entry_t);

	logic [TIME_W-1:0] return_gap_q;
	logic [TIME_W-1:0] return_display_q;

	item_t             item;
	result_t           result;
	entry_t            ent_rdata;
	entry_t            ent_wdata;
	logic [IW-1:0]     mem_raddr;
	logic [IW-1:0]     mem_waddr;
	logic [ADDR_W-1:0] addr_rdata;
	logic [ADDR_W-1:0] addr_wdata;
	logic              addr_we;
	logic              ent_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			return_gap_q     <= RETURN_GAP_RESET;
			return_display_q <= RETURN_DISPLAY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RETURN_GAP:     return_gap_q     <= cfg_wdata;
				CFG_RETURN_DISPLAY: return_display_q <= cfg_wdata;
			endcase
		end
	end

	assign item.op              = opcode_t'(opcode);
	assign item.address         = address;
	assign item.address_present = address_present;
	assign item.now_ms          = now_ms;
	assign item.time_valid      = time_valid;
	assign item.day_number      = day_number;

	dst_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(TABLE_DEPTH)
	) u_addr_ram (
		.clk  (clk),
		.we   (addr_we),
		.waddr(mem_waddr),
		.wdata(addr_wdata),
		.raddr(mem_raddr),
		.rdata(addr_rdata)
	);

	dst_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(mem_waddr),
		.wdata(ent_wdata),
		.raddr(mem_raddr),
		.rdata(ent_rdata)
	);

	dst_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.item          (item),
		.return_gap    (return_gap_q),
		.return_display(return_display_q),
		.busy          (busy),
		.mem_raddr     (mem_raddr),
		.addr_rdata    (addr_rdata),
		.ent_rdata     (ent_rdata),
		.addr_we       (addr_we),
		.ent_we        (ent_we),
		.mem_waddr     (mem_waddr),
		.addr_wdata    (addr_wdata),
		.ent_wdata     (ent_wdata),
		.result        (result),
		.done          (done)
	);

	assign found       = result.found;
	assign sight_count = result.sight_count;
	assign sight_class = result.sight_class;
	assign gap_ms      = result.gap_ms;
	assign dropped     = result.dropped;

endmodule

>>> test/tb_daily_sighting_tracker.sv
// Self-checking testbench for the daily sighting tracker: directed and random words, scoreboard.
module tb_daily_sighting_tracker;
	import dst_pkg::*;

	localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int POOL_SIZE   = 12;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                opcode;
	logic [ADDR_W-1:0]   address;
	logic                address_present;
	logic [TIME_W-1:0]   now_ms;
	logic                time_valid;
	logic [DAY_W-1:0]    day_number;
	logic                done;
	logic                found;
	logic [COUNT_W-1:0]  sight_count;
	logic [1:0]          sight_class;
	logic [TIME_W-1:0]   gap_ms;
	logic                dropped;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [TIME_W-1:0]   cfg_wdata;

	daily_sighting_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.address(address),
		.address_present(address_present),
		.now_ms(now_ms),
		.time_valid(time_valid),
		.day_number(day_number),
		.done(done),
		.found(found),
		.sight_count(sight_count),
		.sight_class(sight_class),
		.gap_ms(gap_ms),
		.dropped(dropped),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	class sighting_scoreboard;
		logic [ADDR_W-1:0]  entry_addr [TABLE_DEPTH];
		logic [COUNT_W-1:0] entry_runs [TABLE_DEPTH];
		logic [TIME_W-1:0]  entry_last [TABLE_DEPTH];
		logic [TIME_W-1:0]  entry_back [TABLE_DEPTH];
		logic [TIME_W-1:0]  entry_away [TABLE_DEPTH];
		int                 fill;
		logic [DAY_W-1:0]   day_reg;
		bit                 day_set;
		logic [TIME_W-1:0]  return_gap;
		logic [TIME_W-1:0]  show_window;
		result_t            pending_reports [$];
		int                 failures;

		function new();
			return_gap  = RETURN_GAP_RESET;
			show_window = RETURN_DISPLAY_RESET;
			fill        = 0;
			day_reg     = '0;
			day_set     = 1'b0;
			failures    = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [TIME_W-1:0] value);
			if (idx == CFG_RETURN_GAP) begin
				return_gap = value;
			end else begin
				show_window = value;
			end
		endfunction

		function int holds(logic [ADDR_W-1:0] a);
			for (int i = 0; i < fill; i++) begin
				if (entry_addr[i] == a) return i;
			end
			return -1;
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction

		function result_t report(int slot, logic [TIME_W-1:0] t, logic hit);
			result_t r;
			logic [TIME_W-1:0] since;
			r = '0;
			r.found = hit;
			r.sight_count = entry_runs[slot];
			since = t - entry_back[slot];
			if (entry_runs[slot] <= COUNT_W'(1)) begin
				r.sight_class = CLASS_NEW;
			end else if (since < show_window) begin
				r.sight_class = CLASS_RETURNING;
				r.gap_ms = entry_away[slot];
			end else begin
				r.sight_class = CLASS_SEEN;
			end
			return r;
		endfunction

		function void note_word(item_t w);
			result_t r;
			int slot;
			logic [TIME_W-1:0] away;
			r = '0;
			if (w.address_present) begin
				if (w.op == OP_QUERY) begin
					slot = holds(w.address);
					if (slot >= 0) r = report(slot, w.now_ms, 1'b1);
				end else if (!w.time_valid) begin
					r.dropped = 1'b1;
				end else begin
					if (!day_set || day_reg != w.day_number) begin
						day_reg = w.day_number;
						day_set = 1'b1;
						fill = 0;
					end
					slot = holds(w.address);
					if (slot >= 0) begin
						away = w.now_ms - entry_last[slot];
						if (away > return_gap) begin
							if (entry_runs[slot] != COUNT_MAX) begin
								entry_runs[slot] = entry_runs[slot] + COUNT_W'(1);
							end
							entry_back[slot] = w.now_ms;
							entry_away[slot] = away;
						end
						entry_last[slot] = w.now_ms;
						r = report(slot, w.now_ms, 1'b1);
					end else if (fill >= TABLE_DEPTH) begin
						r.dropped = 1'b1;
					end else begin
						slot = fill;
						fill++;
						entry_addr[slot] = w.address;
						entry_runs[slot] = COUNT_W'(1);
						entry_last[slot] = w.now_ms;
						entry_back[slot] = '0;
						entry_away[slot] = '0;
						r = report(slot, w.now_ms, 1'b0);
					end
				end
			end
			pending_reports.push_back(r);
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (pending_reports.size() == 0) begin
				$error("result word with none expected");
				failures++;
				return;
			end
			want = pending_reports.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				failures++;
			end
			if (got.sight_count !== want.sight_count) begin
				$error("sight_count: expected %0d, got %0d", want.sight_count, got.sight_count);
				failures++;
			end
			if (got.sight_class !== want.sight_class) begin
				$error("sight_class: expected %0d, got %0d", want.sight_class, got.sight_class);
				failures++;
			end
			if (got.gap_ms !== want.gap_ms) begin
				$error("gap_ms: expected %0d, got %0d", want.gap_ms, got.gap_ms);
				failures++;
			end
			if (got.dropped !== want.dropped) begin
				$error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
				failures++;
			end
		endfunction
	endclass

	sighting_scoreboard sb = new();

	int                idle_pct;
	int                cycles;
	logic [TIME_W-1:0] clock_ms;
	logic [DAY_W-1:0]  today;
	logic [ADDR_W-1:0] pool [POOL_SIZE];

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_word(result_t'({found, sight_count, sight_class, gap_ms, dropped}));
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_daily_sighting_tracker: done, errors");
			$finish;
		end
	end

	function automatic item_t pack_word(opcode_t op, logic [ADDR_W-1:0] a, logic p,
			logic [TIME_W-1:0] t, logic v, logic [DAY_W-1:0] d);
		item_t w;
		w.op = op;
		w.address = a;
		w.address_present = p;
		w.now_ms = t;
		w.time_valid = v;
		w.day_number = d;
		return w;
	endfunction

	// start stays high into the next word unless the sender decides to idle
	task automatic send_word(item_t w);
		start <= 1'b1;
		opcode <= w.op;
		address <= w.address;
		address_present <= w.address_present;
		now_ms <= w.now_ms;
		time_valid <= w.time_valid;
		day_number <= w.day_number;
		do @(posedge clk); while (busy);
		sb.note_word(w);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0 || busy);
	endtask

	task automatic write_cfg(logic [TIME_W-1:0] gap_val, logic [TIME_W-1:0] window_val);
		cfg_we <= 1'b1;
		cfg_index <= CFG_RETURN_GAP;
		cfg_wdata <= gap_val;
		@(posedge clk);
		cfg_index <= CFG_RETURN_DISPLAY;
		cfg_wdata <= window_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(CFG_RETURN_GAP, gap_val);
		sb.set_reg(CFG_RETURN_DISPLAY, window_val);
	endtask

	task automatic new_day();
		today = today + DAY_W'($urandom_range(1, 40));
		foreach (pool[i]) pool[i] = ADDR_W'($urandom);
	endtask

	task automatic directed_words();
		send_word(pack_word(OP_QUERY, 24'h000000, 1'b0, 32'd0, 1'b1, 16'd0));
		send_word(pack_word(OP_RECORD, 24'hFFFFFF, 1'b0, 32'd5, 1'b1, 16'd0));
		send_word(pack_word(OP_RECORD, 24'hABCDEF, 1'b1, 32'd5, 1'b0, 16'd0));
		send_word(pack_word(OP_QUERY, 24'hFFFFFF, 1'b1, 32'd5, 1'b0, 16'd0));
		send_word(pack_word(OP_RECORD, 24'h000000, 1'b1, 32'd0, 1'b1, 16'd0));
		send_word(pack_word(OP_RECORD, 24'hFFFFFF, 1'b1, 32'hFFF0_0000, 1'b1, 16'd0));
		// return across the time wrap, stored return time is zero
		send_word(pack_word(OP_RECORD, 24'hFFFFFF, 1'b1, 32'd0, 1'b1, 16'd0));
		send_word(pack_word(OP_QUERY, 24'hFFFFFF, 1'b1, 32'd599999, 1'b0, 16'hFFFF));
		send_word(pack_word(OP_QUERY, 24'hFFFFFF, 1'b1, 32'd600000, 1'b0, 16'hFFFF));
		// gap exactly at the threshold is not a return, one more is
		send_word(pack_word(OP_RECORD, 24'h000000, 1'b1, 32'd300000, 1'b1, 16'd0));
		send_word(pack_word(OP_RECORD, 24'h000000, 1'b1, 32'd600001, 1'b1, 16'd0));
		send_word(pack_word(OP_RECORD, 24'h000000, 1'b1, 32'd600002, 1'b0, 16'd5));
		send_word(pack_word(OP_QUERY, 24'h000000, 1'b1, 32'd600003, 1'b1, 16'd5));
		send_word(pack_word(OP_RECORD, 24'h123456, 1'b1, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
		send_word(pack_word(OP_QUERY, 24'h000000, 1'b1, 32'd0, 1'b1, 16'hFFFF));
		send_word(pack_word(OP_QUERY, 24'h123456, 1'b0, 32'd0, 1'b1, 16'hFFFF));
		send_word(pack_word(OP_QUERY, 24'h123456, 1'b1, 32'd0, 1'b1, 16'hFFFF));
	endtask

	task automatic fill_table();
		item_t w;
		logic [ADDR_W-1:0] last_addr;
		new_day();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			clock_ms = clock_ms + $urandom_range(0, 50);
			last_addr = {17'($urandom), 7'(i)};
			send_word(pack_word(OP_RECORD, last_addr, 1'b1, clock_ms, 1'b1, today));
		end
		w = pack_word(OP_RECORD, 24'h0, 1'b1, clock_ms, 1'b1, today);
		do w.address = ADDR_W'($urandom); while (sb.holds(w.address) >= 0);
		send_word(w);
		send_word(pack_word(OP_QUERY, last_addr, 1'b1, clock_ms, 1'b1, today));
		clock_ms = clock_ms + 32'd400000;
		send_word(pack_word(OP_RECORD, last_addr, 1'b1, clock_ms, 1'b1, today));
	endtask

	task automatic repeat_returns();
		logic [ADDR_W-1:0] a;
		new_day();
		a = pool[0];
		for (int i = 0; i < 20; i++) begin
			clock_ms = clock_ms + 1;
			send_word(pack_word(OP_RECORD, a, 1'b1, clock_ms, 1'b1, today));
		end
		send_word(pack_word(OP_QUERY, a, 1'b1, clock_ms, 1'b0, today));
	endtask

	task automatic random_words(int n);
		item_t w;
		int sent;
		int roll;
		logic [TIME_W-1:0] dt;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 3) new_day();
			roll = $urandom_range(99);
			if (roll < 75) begin
				dt = $urandom_range(0, 2500);
			end else if (roll < 95) begin
				dt = $urandom_range(0, 12000);
			end else begin
				dt = $urandom;
			end
			clock_ms = clock_ms + dt;
			w.op = ($urandom_range(99) < 35) ? OP_QUERY : OP_RECORD;
			if ($urandom_range(99) < 85) begin
				w.address = pool[$urandom_range(POOL_SIZE - 1)];
			end else begin
				w.address = ADDR_W'($urandom);
				if ($urandom_range(1)) pool[$urandom_range(POOL_SIZE - 1)] = w.address;
			end
			w.address_present = ($urandom_range(99) >= 5);
			w.now_ms = clock_ms;
			w.time_valid = ($urandom_range(99) >= 5);
			w.day_number = (w.op == OP_QUERY && $urandom_range(1)) ? DAY_W'($urandom) : today;
			send_word(w);
			if (w.address_present) sent++;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_RECORD;
		address = '0;
		address_present = 1'b0;
		now_ms = '0;
		time_valid = 1'b0;
		day_number = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_RETURN_GAP;
		cfg_wdata = '0;
		cycles = 0;
		idle_pct = 30;
		clock_ms = 32'h0010_0000;
		today = 16'h0100;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_words();
		fill_table();
		drain();

		write_cfg(32'd1000, 32'd5000);
		new_day();
		random_words(60);
		drain();
		random_words(60);
		drain();

		idle_pct = 52;
		write_cfg(32'd0, 32'hFFFF_FFFF);
		new_day();
		random_words(130);
		drain();

		idle_pct = 0;
		repeat_returns();
		drain();

		write_cfg(32'hFFFF_FFFF, 32'd0);
		new_day();
		random_words(120);
		drain();

		write_cfg($urandom_range(0, 4000), $urandom_range(0, 8000));
		new_day();
		random_words(80);
		drain();

		repeat (TABLE_DEPTH + 4) @(posedge clk);
		if (sb.failures == 0) begin
			$display("tb_daily_sighting_tracker: done, clean");
		end else begin
			$display("tb_daily_sighting_tracker: done, errors");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/dst_pkg.sv
rtl/core/dst_ram.sv
rtl/core/dst_engine.sv
rtl/core/daily_sighting_tracker.sv
test/tb_daily_sighting_tracker.sv
